// File: sv/signed_integer_to_ascii_radix_defines.svh
// assertion macros shared by the conversion block
`ifndef SIGNED_INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`define SIGNED_INTEGER_TO_ASCII_RADIX_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SITOA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sitoa assertion failed");

// next-cycle implication, checked out of reset
`define SITOA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sitoa assertion failed");

`endif

// File: sv/sitoa_pkg.sv
`default_nettype none

package sitoa_pkg;

   // parameter defaults
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int MAX_DIGITS_DEF  = 32;

   // field widths
   localparam int RADIX_W    = 5;
   localparam int DIGIT_W    = 4;
   localparam int CHAR_W     = 8;
   localparam int LEN_W      = 6;
   localparam int RSP_DATA_W = 16;

   // radix register
   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

   // character codes
   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] ASCII_ALPHA = 8'd55;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_NONE   = 8'd0;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

   // divider status towards the sequencer
   typedef struct packed {
      logic busy;
      logic done;
      logic quo_zero;
   } div_status_type;

   // digit value to its ascii character
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] ext;
      ext = CHAR_W'(d);
      return (d < DIGIT_TEN) ? ASCII_ZERO + ext : ASCII_ALPHA + ext;
   endfunction

endpackage

`default_nettype wire

// File: sv/sitoa_divider.sv
`default_nettype none

module sitoa_divider #(
   parameter int VALUE_WIDTH = sitoa_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [VALUE_WIDTH-1:0]         dividend,
   input  wire logic [sitoa_pkg::RADIX_W-1:0]  divisor,
   output logic [VALUE_WIDTH-1:0]              quotient,
   output logic [sitoa_pkg::DIGIT_W-1:0]       remainder,
   output sitoa_pkg::div_status_type           status
);
   import sitoa_pkg::*;

   localparam int CNT_W = $clog2(VALUE_WIDTH);

   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [RADIX_W-1:0] trial;
   logic [RADIX_W-1:0] diff;
   logic               ge;

   // one restoring step: bring down the next dividend bit
   assign trial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign diff  = trial - divisor;
   assign ge    = (trial >= divisor);

   // sequencing of the bit steps
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(VALUE_WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_WIDTH-2:0], ge};
         rem_in = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign quotient        = quo_ff;
   assign remainder       = rem_ff;
   assign status.busy     = busy_ff;
   assign status.done     = done_ff;
   assign status.quo_zero = (quo_ff == '0);

endmodule

`default_nettype wire

// File: sv/sitoa_digit_ram.sv
`default_nettype none

module sitoa_digit_ram #(
   parameter int DEPTH  = sitoa_pkg::MAX_DIGITS_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [ADDR_W-1:0]           wr_addr,
   input  wire logic [sitoa_pkg::DIGIT_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]           rd_addr,
   output logic [sitoa_pkg::DIGIT_W-1:0]    rd_data
);
   import sitoa_pkg::*;

   logic [DIGIT_W-1:0] mem [DEPTH];
   logic [DIGIT_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/signed_integer_to_ascii_radix.sv
// Converts one signed VALUE_WIDTH-bit word on req_ into its text in the base held in the
// radix register (2 to 16, reset 10), one character per rsp_ word, most significant first:
// a leading '-' for negative values, then '0'-'9' and 'A'-'F'. The last character has
// rsp_tlast set and carries the text length plus one for a terminator; the terminator is not
// sent. A radix outside 2 to 16 gives a single word with character 0, length 0, tlast and
// tuser (bad radix) set. One word is converted at a time. Each digit comes from a bit-serial
// divider, one digit after another; then the characters go out one per cycle while the
// output is taken. The digit memory needs no clearing pass after reset. The radix may
// be written only while idle.
`default_nettype none
`include "signed_integer_to_ascii_radix_defines.svh"

module signed_integer_to_ascii_radix #(
   parameter int VALUE_WIDTH = sitoa_pkg::VALUE_WIDTH_DEF,
   parameter int MAX_DIGITS  = sitoa_pkg::MAX_DIGITS_DEF,
   localparam int REQ_DATA_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // radix register write
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [sitoa_pkg::RADIX_W-1:0]     csr_data,
   // input words
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [REQ_DATA_W-1:0]             req_tdata,   // value, zero pad
   // output words
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [sitoa_pkg::RSP_DATA_W-1:0]       rsp_tdata,   // character[7:0], length, pad
   output logic                                   rsp_tlast,
   output logic [0:0]                             rsp_tuser    // bad_radix
);
   import sitoa_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = $clog2(MAX_DIGITS);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ERR  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_SIGN = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic               neg_ff, neg_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_bad_ff, rsp_bad_in;

   logic [VALUE_WIDTH-1:0] req_value;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic                   req_fire;
   logic                   radix_ok;
   logic                   slot_free;
   logic                   load;
   logic                   advance;
   logic [CNT_W-1:0]       count_next;
   logic [LEN_W-1:0]       len_total;

   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic [VALUE_WIDTH-1:0] div_quotient;
   logic [DIGIT_W-1:0]     div_remainder;
   div_status_type         div_stat;

   logic                   ram_wr_en;
   logic [IDX_W-1:0]       ram_rd_addr;
   logic [DIGIT_W-1:0]     ram_rd_data;

   // input decode
   assign req_value  = req_tdata[VALUE_WIDTH-1:0];
   assign magnitude  = req_value[VALUE_WIDTH-1] ? (~req_value + VALUE_WIDTH'(1)) : req_value;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign radix_ok   = (radix_ff >= RADIX_MIN) && (radix_ff <= RADIX_MAX);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign count_next = count_ff + 1'b1;
   assign len_total  = LEN_W'(count_ff) + LEN_W'(neg_ff) + LEN_W'(1);

   // radix register
   assign csr_ready = 1'b1;
   assign radix_in  = (csr_valid && csr_ready) ? csr_data : radix_ff;

   // divider and digit memory
   sitoa_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (radix_ff),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_stat)
   );

   sitoa_digit_ram #(
      .DEPTH  (MAX_DIGITS),
      .ADDR_W (IDX_W)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (div_remainder),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // read one entry ahead so the data follows idx_ff
   assign ram_rd_addr  = advance ? (idx_ff - 1'b1) : idx_ff;
   assign div_dividend = (state_ff == ST_IDLE) ? magnitude : div_quotient;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      neg_in      = neg_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      div_start   = 1'b0;
      ram_wr_en   = 1'b0;
      advance     = 1'b0;
      load        = 1'b0;
      rsp_char_in = rsp_char_ff;
      rsp_len_in  = rsp_len_ff;
      rsp_last_in = rsp_last_ff;
      rsp_bad_in  = rsp_bad_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (radix_ok) begin
                  neg_in    = req_value[VALUE_WIDTH-1];
                  count_in  = '0;
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in = ST_ERR;
               end
            end
         end
         ST_ERR: begin
            if (slot_free) begin
               load        = 1'b1;
               rsp_char_in = CHAR_NONE;
               rsp_len_in  = '0;
               rsp_last_in = 1'b1;
               rsp_bad_in  = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               ram_wr_en = 1'b1;
               count_in  = count_next;
               if (!div_stat.quo_zero && (count_next < CNT_W'(MAX_DIGITS))) begin
                  div_start = 1'b1;
               end else begin
                  idx_in   = count_ff[IDX_W-1:0];
                  state_in = ST_SIGN;
               end
            end
         end
         ST_SIGN: begin
            if (!neg_ff) begin
               state_in = ST_EMIT;
            end else if (slot_free) begin
               load        = 1'b1;
               rsp_char_in = ASCII_MINUS;
               rsp_len_in  = (count_ff == '0) ? len_total : '0;
               rsp_last_in = (count_ff == '0);
               rsp_bad_in  = 1'b0;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               load        = 1'b1;
               rsp_char_in = digit_char(ram_rd_data);
               rsp_len_in  = (idx_ff == '0) ? len_total : '0;
               rsp_last_in = (idx_ff == '0);
               rsp_bad_in  = 1'b0;
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  advance = 1'b1;
                  idx_in  = idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output word valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         neg_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         neg_ff       <= neg_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   // output word packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - CHAR_W - LEN_W){1'b0}}, rsp_len_ff, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_bad_ff;

   // checks
   `SITOA_ASSERT_IMPL(a_err_word, clock, reset, rsp_tvalid && rsp_tuser[0],
                      rsp_tlast && (rsp_tdata == '0))
   `SITOA_ASSERT_IMPL(a_done_in_div, clock, reset, div_stat.done, state_ff == ST_DIV)
   `SITOA_ASSERT_IMPL(a_idle_quiet, clock, reset, state_ff == ST_IDLE, !div_stat.busy)
   `SITOA_ASSERT_NEXT(a_last_to_idle, clock, reset,
                      (state_ff == ST_EMIT) && load && (idx_ff == '0), state_ff == ST_IDLE)

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import sitoa_pkg::*;

   // how the two sides leave gaps in the traffic
   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   // one expected character word
   typedef struct {
      logic [CHAR_W-1:0] character;
      logic              last;
      logic [LEN_W-1:0]  length;
      logic              bad_radix;
   } text_char_type;

   // expected text of every accepted value, oldest first
   class text_scoreboard_type;
      text_char_type  pending_chars[$];
      logic [RADIX_W-1:0] radix;
      int unsigned errors;
      int unsigned values_seen;
      int unsigned chars_checked;
      int unsigned bad_radix_seen;

      function new();
         radix = RADIX_RESET;
         errors = 0;
         values_seen = 0;
         chars_checked = 0;
         bad_radix_seen = 0;
      endfunction

      function void set_radix(logic [RADIX_W-1:0] r);
         radix = r;
      endfunction

      function int outstanding();
         return pending_chars.size();
      endfunction

      // work out the text of one accepted value in the current base
      function void note_value(logic [31:0] value);
         logic [31:0]        mag;
         logic [31:0]        base;
         logic [DIGIT_W-1:0] digits [MAX_DIGITS_DEF];
         logic [DIGIT_W-1:0] d;
         logic               neg;
         int                 n;
         int                 total;
         text_char_type      c;
         values_seen++;
         if (radix < RADIX_MIN || radix > RADIX_MAX) begin
            c = '{character: CHAR_NONE, last: 1'b1, length: '0, bad_radix: 1'b1};
            pending_chars.push_back(c);
            bad_radix_seen++;
            return;
         end
         // magnitude as unsigned, so the most negative value survives
         neg = value[31];
         mag = neg ? (~value + 32'd1) : value;
         base = 32'(radix);
         n = 0;
         do begin
            digits[n] = DIGIT_W'(mag % base);
            n++;
            mag = mag / base;
         end while (mag != 0 && n < MAX_DIGITS_DEF);
         total = n + (neg ? 1 : 0);
         if (neg) begin
            c = '{character: ASCII_MINUS, last: (total == 1), length: '0, bad_radix: 1'b0};
            pending_chars.push_back(c);
         end
         // most significant digit first
         for (int i = n - 1; i >= 0; i--) begin
            d = digits[i];
            c.character = (d < DIGIT_TEN) ? ASCII_ZERO + CHAR_W'(d) : ASCII_ALPHA + CHAR_W'(d);
            c.last = (i == 0);
            c.length = (i == 0) ? LEN_W'(total + 1) : '0;
            c.bad_radix = 1'b0;
            pending_chars.push_back(c);
         end
      endfunction

      // compare one output word with the oldest expectation
      function void check_char(logic [CHAR_W-1:0] ch, logic last, logic [LEN_W-1:0] len,
                               logic bad);
         text_char_type e;
         chars_checked++;
         if (pending_chars.size() == 0) begin
            $error("unexpected output word: character %h last %b length %0d bad_radix %b",
                   ch, last, len, bad);
            errors++;
            return;
         end
         e = pending_chars.pop_front();
         if (ch !== e.character) begin
            $error("character: expected %h, got %h", e.character, ch);
            errors++;
         end
         if (last !== e.last) begin
            $error("last: expected %b, got %b", e.last, last);
            errors++;
         end
         if (len !== e.length) begin
            $error("length: expected %0d, got %0d", e.length, len);
            errors++;
         end
         if (bad !== e.bad_radix) begin
            $error("bad_radix: expected %b, got %b", e.bad_radix, bad);
            errors++;
         end
      endfunction
   endclass

   localparam int HOLD_CYCLES = 3000;
   localparam int N_PHASES = 12;

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [RADIX_W-1:0]    csr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [31:0]           req_tdata;     // value
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;     // character[7:0], length[13:8], pad
   logic                  rsp_tlast;
   logic [0:0]            rsp_tuser;     // bad_radix

   text_scoreboard_type sb = new();
   idle_mode_type idle_mode = IDLE_NONE;
   logic hold_req = 1'b0;
   int hold_left = 0;
   int settings_written = 0;

   // fixed plan: base, idling and length of each phase
   int            plan_radix [N_PHASES] = '{10, 16, 2, 7, 3, 31, 8, 13, 5, 1, 17, 10};
   idle_mode_type plan_mode  [N_PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                            IDLE_NONE, IDLE_BOTH, IDLE_RECV, IDLE_SEND,
                                            IDLE_BOTH, IDLE_RECV, IDLE_NONE, IDLE_BOTH};
   int            plan_count [N_PHASES] = '{60, 50, 30, 50, 30, 20, 50, 50, 50, 10, 10, 60};

   signed_integer_to_ascii_radix u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // output side: stalls, and the long hold-off when asked
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (idle_mode == IDLE_RECV) begin
            rsp_tready <= ($urandom_range(99) >= 85);
         end else if (idle_mode == IDLE_BOTH) begin
            rsp_tready <= ($urandom_range(99) >= 29);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // check every accepted output word
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_char(rsp_tdata[CHAR_W-1:0], rsp_tlast, rsp_tdata[CHAR_W+LEN_W-1:CHAR_W],
                       rsp_tuser[0]);
   end

   // offer one value, with random gaps in front; called and left at a falling edge
   task automatic send_value(input logic [31:0] v);
      int idle_pct;
      idle_pct = (idle_mode == IDLE_SEND) ? 85 : (idle_mode == IDLE_BOTH) ? 29 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata <= $urandom;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= v;
      do @(posedge clock); while (!req_tready);
      sb.note_value(v);
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   // radix write once the block has gone quiet
   task automatic write_radix(input logic [RADIX_W-1:0] r);
      wait_drained();
      repeat (8) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= r;
      do @(posedge clock); while (!csr_ready);
      sb.set_radix(r);
      settings_written++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_mode(input idle_mode_type m);
      @(posedge clock);
      idle_mode = m;
      @(negedge clock);
   endtask

   // mix of full-range, small, shifted and edge values
   function automatic logic [31:0] random_value();
      logic [31:0] v;
      int sel;
      sel = $urandom_range(9);
      if (sel <= 3) begin
         v = $urandom;
      end else if (sel <= 5) begin
         v = $urandom_range(300);
         if ($urandom_range(1)) v = -v;
      end else if (sel <= 7) begin
         v = $urandom >> $urandom_range(31);
         if ($urandom_range(1)) v = -v;
      end else if (sel == 8) begin
         case ($urandom_range(4))
            0: v = 32'h0000_0000;
            1: v = 32'h8000_0000;
            2: v = 32'h7FFF_FFFF;
            3: v = 32'hFFFF_FFFF;
            default: v = 32'h0000_0001;
         endcase
      end else begin
         v = {1'b1, 31'($urandom_range(15))};
      end
      return v;
   endfunction

   initial begin
      int drain;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset base, then hex, binary and out-of-range bases
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'hFFFF_FFFF);
      send_value(32'd9);
      send_value(32'd10);
      send_value(-32'sd10);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'd12345);
      end_burst();
      write_radix(RADIX_MAX);
      send_value(32'h0000_000F);
      send_value(32'h0000_000A);
      send_value(32'h8000_0001);
      send_value(32'h8000_0000);
      send_value(32'hDEAD_BEEF);
      end_burst();
      write_radix(RADIX_MIN);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
      send_value(32'd0);
      send_value(32'hFFFF_FFFF);
      end_burst();
      write_radix(5'd0);
      send_value(32'd77);
      end_burst();
      write_radix(5'd1);
      send_value(32'h8000_0000);
      end_burst();
      write_radix(5'd17);
      send_value(32'd0);
      end_burst();
      write_radix(5'd31);
      send_value(32'h7FFF_FFFF);
      end_burst();

      // random phases
      for (int p = 0; p < N_PHASES; p++) begin
         write_radix(RADIX_W'(plan_radix[p]));
         set_mode(plan_mode[p]);
         // long output hold-off while values keep coming
         if (p == 0) begin
            @(posedge clock);
            hold_req = 1'b1;
            @(negedge clock);
         end
         for (int i = 0; i < plan_count[p]; i++) begin
            // sender pause until every character is out
            if (p == 4 && i == plan_count[p] / 2) begin
               end_burst();
               wait_drained();
               repeat (3) @(negedge clock);
            end
            send_value(random_value());
         end
         end_burst();
      end

      // drain, then let the block settle
      drain = 0;
      while (sb.outstanding() != 0 && drain < 20000) begin
         @(negedge clock);
         drain++;
      end
      repeat (40) @(negedge clock);
      if (sb.outstanding() != 0) begin
         $error("%0d expected characters never arrived", sb.outstanding());
         sb.errors++;
      end

      $display("converted %0d values (%0d with a bad base) into %0d output words",
               sb.values_seen, sb.bad_radix_seen, sb.chars_checked);
      $display("across %0d radix writes, four idling patterns and a long output hold-off",
               settings_written);
      if (sb.errors == 0)
         $display("[signed_integer_to_ascii_radix] OK");
      else
         $display("[signed_integer_to_ascii_radix] ERROR");
      $finish;
   end

   // overall time limit
   initial begin
      #(60_000_000);
      $display("[signed_integer_to_ascii_radix] ERROR");
      $finish;
   end

endmodule

// File: signed_integer_to_ascii_radix.f
+incdir+sv
sv/sitoa_pkg.sv
sv/sitoa_divider.sv
sv/sitoa_digit_ram.sv
sv/signed_integer_to_ascii_radix.sv
tb/tb.sv
